@@ sv/smc_pkg.sv @@
// smc_pkg: shared types and constants of the stable matching checker.
// Holds the transaction structs, command and status codes and scan interface types.
// No dependencies.
package smc_pkg;

	localparam int PERSON_W   = 6;
	localparam int RANK_W     = 7;
	localparam int COUNT_W    = 7;
	localparam int PAIR_SLOTS = 32;
	localparam int PAIR_IDX_W = 5;
	localparam int PAIR_CNT_W = 6;
	localparam int PAIR_W     = 2 * PERSON_W;
	localparam int RANK_READS = 12;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_LOAD_RANK = 2'd1,
		CMD_ADD_PAIR = 2'd2,
		CMD_CHECK    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_ACCEPTED   = 3'd0,
		STAT_SAME       = 3'd1,
		STAT_UNKNOWN    = 3'd2,
		STAT_MATCHED    = 3'd3,
		STAT_VALID      = 3'd4,
		STAT_BLOCKING   = 3'd5,
		STAT_INCOMPLETE = 3'd6,
		STAT_ODD        = 3'd7
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [PERSON_W-1:0] person_a;
		logic [PERSON_W-1:0] person_b;
		logic [RANK_W-1:0]   rank_value;
	} item_t;

	typedef struct packed {
		status_t               status;
		logic [PAIR_IDX_W-1:0] first_pair;
		logic [PAIR_IDX_W-1:0] second_pair;
	} result_t;

	typedef struct packed {
		logic                  start;
		logic [PAIR_CNT_W-1:0] count;
	} scan_req_t;

	typedef struct packed {
		logic                  done;
		logic                  found;
		logic [PAIR_IDX_W-1:0] first;
		logic [PAIR_IDX_W-1:0] second;
	} scan_rsp_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} top_state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_PAIR_I,
		SC_PAIR_J,
		SC_LATCH,
		SC_RANK,
		SC_EVAL,
		SC_DONE
	} scan_state_t;

	// p, q: earlier pair; r, s: later pair
	typedef enum logic [1:0] {
		MATE_P,
		MATE_Q,
		MATE_R,
		MATE_S
	} mate_t;

	// rank lookups of one pair combination, rank of (x, y)
	localparam mate_t RD_X [RANK_READS] = '{
		MATE_P, MATE_P, MATE_S, MATE_S, MATE_Q, MATE_Q,
		MATE_R, MATE_R, MATE_P, MATE_R, MATE_Q, MATE_S
	};
	localparam mate_t RD_Y [RANK_READS] = '{
		MATE_Q, MATE_S, MATE_R, MATE_P, MATE_P, MATE_R,
		MATE_S, MATE_Q, MATE_R, MATE_P, MATE_S, MATE_Q
	};

endpackage

@@ sv/smc_ram.sv @@
// smc_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module smc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/smc_scan.sv @@
// smc_scan: blocking pair search over the combinations of stored pairs, stopping at the first hit.
// Reads the pair list and rank table RAMs one entry per cycle.
// Depends on smc_pkg.
module smc_scan
	import smc_pkg::*;
#(
	parameter int IDX_W = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_req_t               req,
	output scan_rsp_t               rsp,
	output logic [PAIR_IDX_W-1:0]   pair_raddr,
	input  logic [PAIR_W-1:0]       pair_rdata,
	output logic [2*IDX_W-1:0]      rank_raddr,
	input  logic [RANK_W-1:0]       rank_rdata
);

	scan_state_t state_q, state_d;
	logic [PAIR_IDX_W-1:0] i_q, j_q;
	logic [PAIR_CNT_W-1:0] cnt_q;
	logic [3:0] k_q;
	logic found_q;
	logic [IDX_W-1:0] p_q, q_q, r_q, s_q;
	logic [RANK_W-1:0] ranks_q [RANK_READS];

	logic [PAIR_CNT_W-1:0] j_inc, i_inc2;
	logic [3:0] k_sel;
	logic [IDX_W-1:0] x_val, y_val;
	logic hit;

	function automatic logic worse(input logic [RANK_W-1:0] a, input logic [RANK_W-1:0] b);
		logic [RANK_W:0] ea, eb;
		ea = (a == '0) ? '1 : {1'b0, a};
		eb = (b == '0) ? '1 : {1'b0, b};
		return ea > eb;
	endfunction

	assign j_inc  = {1'b0, j_q} + PAIR_CNT_W'(1);
	assign i_inc2 = {1'b0, i_q} + PAIR_CNT_W'(2);
	assign k_sel  = (k_q < 4'(RANK_READS)) ? k_q : '0;

	assign hit = (worse(ranks_q[0], ranks_q[1]) && worse(ranks_q[2], ranks_q[3])) ||
		(worse(ranks_q[4], ranks_q[5]) && worse(ranks_q[6], ranks_q[7])) ||
		(worse(ranks_q[0], ranks_q[8]) && worse(ranks_q[6], ranks_q[9])) ||
		(worse(ranks_q[4], ranks_q[10]) && worse(ranks_q[2], ranks_q[11]));

	always_comb begin
		case (RD_X[k_sel])
			MATE_P: x_val = p_q;
			MATE_Q: x_val = q_q;
			MATE_R: x_val = r_q;
			MATE_S: x_val = s_q;
			default: x_val = p_q;
		endcase
		case (RD_Y[k_sel])
			MATE_P: y_val = p_q;
			MATE_Q: y_val = q_q;
			MATE_R: y_val = r_q;
			MATE_S: y_val = s_q;
			default: y_val = p_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					state_d = (req.count < PAIR_CNT_W'(2)) ? SC_DONE : SC_PAIR_I;
				end
			end
			SC_PAIR_I: state_d = SC_PAIR_J;
			SC_PAIR_J: state_d = SC_LATCH;
			SC_LATCH:  state_d = SC_RANK;
			SC_RANK: begin
				if (k_q == 4'(RANK_READS)) begin
					state_d = SC_EVAL;
				end
			end
			SC_EVAL: begin
				if (hit) begin
					state_d = SC_DONE;
				end else if (j_inc < cnt_q || i_inc2 < cnt_q) begin
					state_d = SC_PAIR_I;
				end else begin
					state_d = SC_DONE;
				end
			end
			SC_DONE: state_d = SC_IDLE;
			default: state_d = SC_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pair_raddr = (state_q == SC_PAIR_J) ? j_q : i_q;
		rank_raddr = {x_val, y_val};
		rsp.done   = (state_q == SC_DONE);
		rsp.found  = found_q;
		rsp.first  = found_q ? i_q : '0;
		rsp.second = found_q ? j_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						i_q     <= '0;
						j_q     <= PAIR_IDX_W'(1);
						cnt_q   <= req.count;
						found_q <= 1'b0;
					end
				end
				SC_LATCH: k_q <= '0;
				SC_RANK:  k_q <= k_q + 4'd1;
				SC_EVAL: begin
					if (hit) begin
						found_q <= 1'b1;
					end else if (j_inc < cnt_q) begin
						j_q <= j_q + PAIR_IDX_W'(1);
					end else if (i_inc2 < cnt_q) begin
						i_q <= i_q + PAIR_IDX_W'(1);
						j_q <= i_inc2[PAIR_IDX_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_PAIR_J) begin
			p_q <= pair_rdata[IDX_W-1:0];
			q_q <= pair_rdata[PERSON_W+IDX_W-1:PERSON_W];
		end
		if (state_q == SC_LATCH) begin
			r_q <= pair_rdata[IDX_W-1:0];
			s_q <= pair_rdata[PERSON_W+IDX_W-1:PERSON_W];
		end
		if (state_q == SC_RANK && k_q != '0) begin
			ranks_q[k_q - 4'd1] <= rank_rdata;
		end
	end

endmodule

@@ sv/stable_matching_checker_core.sv @@
// stable_matching_checker_core: stable roommates matching checker, top level.
// Rank loads and pair adds: one transaction per cycle while result_ready keeps the result register free.
// Clear: 2^(2*ceil(log2(min(MAX_PEOPLE,64)))) rank RAM entries (4096 by default), one zeroed a cycle.
// Check: scans the stored pair combinations, 12 rank RAM reads each, until the first blocking pair.
// Reset runs the same rank RAM clearing pass; no item is taken until it ends.
// Depends on smc_pkg, smc_ram, smc_scan.
module stable_matching_checker_core
	import smc_pkg::*;
#(
	parameter int MAX_PEOPLE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_ready,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data
);

	localparam int PEOPLE_USED = (MAX_PEOPLE > 64) ? 64 : MAX_PEOPLE;
	localparam int IDX_W       = $clog2(PEOPLE_USED);
	localparam int RANK_AW     = 2 * IDX_W;
	localparam int RANK_DEPTH  = 1 << RANK_AW;
	localparam int CAP_INT     = (MAX_PEOPLE > 127) ? 127 : MAX_PEOPLE;
	localparam logic [COUNT_W-1:0] N_CAP = COUNT_W'(CAP_INT);

	top_state_t state_q, state_d;
	logic [COUNT_W-1:0] n_people_q;
	logic [COUNT_W-1:0] n_eff;
	logic [RANK_AW-1:0] clr_addr_q;
	logic [PAIR_CNT_W-1:0] pair_cnt_q;
	logic [PEOPLE_USED-1:0] matched_q;
	logic [PEOPLE_USED-1:0] matched_set;
	logic result_valid_q;
	result_t result_q, result_d;
	logic result_load;

	logic accept, sweep_last;
	logic same, unknown, taken;
	logic [IDX_W-1:0] a_idx, b_idx;

	logic rank_we;
	logic [RANK_AW-1:0] rank_waddr, rank_raddr;
	logic [RANK_W-1:0] rank_wdata, rank_rdata;
	logic pair_we;
	logic [PAIR_IDX_W-1:0] pair_raddr;
	logic [PAIR_W-1:0] pair_rdata;
	scan_req_t scan_req;
	scan_rsp_t scan_rsp;

	assign n_eff      = (n_people_q > N_CAP) ? N_CAP : n_people_q;
	assign a_idx      = item.person_a[IDX_W-1:0];
	assign b_idx      = item.person_b[IDX_W-1:0];
	assign same       = (item.person_a == item.person_b);
	assign unknown    = ({1'b0, item.person_a} >= n_eff) || ({1'b0, item.person_b} >= n_eff);
	assign taken      = matched_q[a_idx] || matched_q[b_idx] ||
		(pair_cnt_q >= PAIR_CNT_W'(PAIR_SLOTS));
	assign matched_set = (PEOPLE_USED'(1) << a_idx) | (PEOPLE_USED'(1) << b_idx);
	assign sweep_last = (clr_addr_q == '1);
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && item.cmd == CMD_CLEAR) begin
					state_d = ST_CLEAR;
				end else if (accept && item.cmd == CMD_CHECK && !n_eff[0]) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		item_ready  = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
		rank_we     = 1'b0;
		rank_waddr  = {a_idx, b_idx};
		rank_wdata  = item.rank_value;
		pair_we     = 1'b0;
		scan_req.start = 1'b0;
		scan_req.count = pair_cnt_q;
		result_load = 1'b0;
		result_d    = '{status: STAT_ACCEPTED, first_pair: '0, second_pair: '0};
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				rank_we    = 1'b1;
				rank_waddr = clr_addr_q;
				rank_wdata = '0;
				result_load = (state_q == ST_CLEAR) && sweep_last;
			end
			ST_IDLE: begin
				if (accept) begin
					case (item.cmd)
						CMD_LOAD_RANK: begin
							result_load = 1'b1;
							if (same) begin
								result_d.status = STAT_SAME;
							end else if (unknown) begin
								result_d.status = STAT_UNKNOWN;
							end else begin
								rank_we = 1'b1;
							end
						end
						CMD_ADD_PAIR: begin
							result_load = 1'b1;
							if (same) begin
								result_d.status = STAT_SAME;
							end else if (unknown) begin
								result_d.status = STAT_UNKNOWN;
							end else if (taken) begin
								result_d.status = STAT_MATCHED;
							end else begin
								pair_we = 1'b1;
							end
						end
						CMD_CHECK: begin
							if (n_eff[0]) begin
								result_load = 1'b1;
								result_d.status = STAT_ODD;
							end else begin
								scan_req.start = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_rsp.done) begin
					result_load = 1'b1;
					if (scan_rsp.found) begin
						result_d.status      = STAT_BLOCKING;
						result_d.first_pair  = scan_rsp.first;
						result_d.second_pair = scan_rsp.second;
					end else if (n_eff == {pair_cnt_q, 1'b0}) begin
						result_d.status = STAT_VALID;
					end else begin
						result_d.status = STAT_INCOMPLETE;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			n_people_q     <= '0;
			clr_addr_q     <= '0;
			pair_cnt_q     <= '0;
			matched_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				n_people_q <= cfg_data;
			end
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + RANK_AW'(1);
			end
			if (accept && item.cmd == CMD_CLEAR) begin
				clr_addr_q <= '0;
				pair_cnt_q <= '0;
				matched_q  <= '0;
			end
			if (pair_we) begin
				pair_cnt_q <= pair_cnt_q + PAIR_CNT_W'(1);
				matched_q  <= matched_q | matched_set;
			end
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q <= result_d;
		end
	end

	smc_ram #(
		.WIDTH(RANK_W),
		.DEPTH(RANK_DEPTH)
	) u_rank_ram (
		.clk  (clk),
		.we   (rank_we),
		.waddr(rank_waddr),
		.wdata(rank_wdata),
		.raddr(rank_raddr),
		.rdata(rank_rdata)
	);

	smc_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(PAIR_SLOTS)
	) u_pair_ram (
		.clk  (clk),
		.we   (pair_we),
		.waddr(pair_cnt_q[PAIR_IDX_W-1:0]),
		.wdata({item.person_b, item.person_a}),
		.raddr(pair_raddr),
		.rdata(pair_rdata)
	);

	smc_scan #(
		.IDX_W(IDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (scan_req),
		.rsp       (scan_rsp),
		.pair_raddr(pair_raddr),
		.pair_rdata(pair_rdata),
		.rank_raddr(rank_raddr),
		.rank_rdata(rank_rdata)
	);

endmodule
